// ----- hdl/dha_pkg.sv -----
// Shared types, register codes and constants for the displacement histogram
// accumulator. No dependencies; imported by the top level.
`default_nettype none

package dha_pkg;

  // Default bin count per species and number of species classes
  localparam int BINS_DEFAULT = 256;
  localparam int NUM_SPECIES  = 5;

  // Charge thresholds that separate the species classes
  localparam logic [7:0] CHARGE_T1 = 8'd3;
  localparam logic [7:0] CHARGE_T2 = 8'd7;
  localparam logic [7:0] CHARGE_T3 = 8'd9;
  localparam logic [7:0] CHARGE_T4 = 8'd11;

  // Reset values of the configuration registers
  localparam logic [30:0] BOX_SIZE_RST    = 31'd0;
  localparam logic [1:0]  AXIS_MODE_RST   = 2'd0;
  localparam logic [31:0] FAST_THRESH_RST = 32'd0;
  localparam logic [31:0] BIN_RECIP_RST   = 32'd65536;
  localparam logic [8:0]  BIN_COUNT_RST   = 9'd256;

  // Item modes
  localparam logic MODE_ACCUM = 1'b0;
  localparam logic MODE_READ  = 1'b1;

  // Distance selection
  localparam logic [1:0] AXIS_RADIAL = 2'd0;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_BOX_SIZE    = 3'd0,
    REG_AXIS_MODE   = 3'd1,
    REG_FAST_THRESH = 3'd2,
    REG_BIN_RECIP   = 3'd3,
    REG_BIN_COUNT   = 3'd4
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIFF,
    ST_MAG,
    ST_MIN,
    ST_SQR,
    ST_SQA,
    ST_ROOT,
    ST_BMUL,
    ST_BCHK,
    ST_ADDR,
    ST_MRD,
    ST_UPD,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic               mode;
    logic signed [31:0] old_x;
    logic signed [31:0] old_y;
    logic signed [31:0] old_z;
    logic signed [31:0] new_x;
    logic signed [31:0] new_y;
    logic signed [31:0] new_z;
    logic [7:0]         ion_charge;
    logic [2:0]         read_species;
    logic [7:0]         read_bin;
  } in_item_t;

  typedef struct packed {
    logic [31:0] distance;
    logic [2:0]  species;
    logic [7:0]  bin_index;
    logic        binned;
    logic        summed;
    logic [31:0] hist_count;
    logic [63:0] square_sum;
  } out_item_t;

  // Sort a charge into its species class
  function automatic logic [2:0] classify_charge(input logic [7:0] charge);
    logic [2:0] sp;
    if (charge < CHARGE_T1) begin
      sp = 3'd0;
    end else if (charge < CHARGE_T2) begin
      sp = 3'd1;
    end else if (charge < CHARGE_T3) begin
      sp = 3'd2;
    end else if (charge < CHARGE_T4) begin
      sp = 3'd3;
    end else begin
      sp = 3'd4;
    end
    return sp;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/displacement_histogram_accumulator_unit.sv -----
// Displacement histogram accumulator: a radial accumulate item runs through a 32-step
// root unit, which is skipped when the radial square sum overflows and in single-axis mode.
// Items are taken one at a time; the output register frees the input while a result waits.
// Reset (synchronous, rst_n low) clears control, sums and configuration, then a clearing
// pass writes zero to all 5 * BINS histogram entries, one per cycle, before items are taken.
// Depends on dha_pkg.
`default_nettype none

module displacement_histogram_accumulator_unit
  import dha_pkg::*;
#(
  parameter int BINS = BINS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  // input items
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  // result items
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data,
  // configuration writes
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  localparam int DEPTH  = NUM_SPECIES * BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BIN_W  = (BINS > 1) ? $clog2(BINS) : 1;

  // Configuration registers
  logic [30:0] box_size_r;
  logic [1:0]  axis_mode_r;
  logic [31:0] fast_thresh_r;
  logic [31:0] bin_recip_r;
  logic [8:0]  bin_count_r;

  // Control
  state_t              state_r, state_nxt;
  logic                out_valid_r;
  logic [ADDR_W-1:0]   clr_cnt_r;
  logic [63:0]         sums_r [NUM_SPECIES];

  // Datapath
  logic                mode_r;
  logic signed [31:0]  old_r [3];
  logic signed [31:0]  new_r [3];
  logic signed [32:0]  d_r [3];
  logic [32:0]         m0_r [3];
  logic [32:0]         m1_r [3];
  logic [32:0]         m2_r [3];
  logic [31:0]         ax_r [3];
  logic [1:0]          sq_cnt_r;
  logic [63:0]         prod_r;
  logic [63:0]         sq_r;
  logic                ovf_r;
  logic [63:0]         rem_r;
  logic [63:0]         res_r;
  logic [63:0]         bit_r;
  logic [31:0]         dist_r;
  logic [2:0]          sp_r;
  logic [BIN_W-1:0]    bin_r;
  logic [7:0]          idx8_r;
  logic                hit_r;
  logic                summed_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [31:0]         mem_q_r;
  out_item_t           out_r;

  // Histogram memory
  logic [31:0]         hist_mem [DEPTH];
  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [31:0]         mem_wdata;

  // Shared multiplier operands
  logic [31:0]         mul_a;
  logic [31:0]         mul_b;

  // Square accumulation
  logic [64:0]         sq_sum;
  logic                ovf_now;

  // Root step
  logic [63:0]         root_trial;
  logic                root_ge;
  logic [63:0]         rem_nxt;
  logic [63:0]         res_nxt;

  // Bin check
  logic [31:0]         bin_idx;
  logic [31:0]         bin_limit;
  logic                binned_now;

  // Sum update
  logic [64:0]         sum_add;

  logic                in_acc;
  logic                out_load;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_size_r    <= BOX_SIZE_RST;
      axis_mode_r   <= AXIS_MODE_RST;
      fast_thresh_r <= FAST_THRESH_RST;
      bin_recip_r   <= BIN_RECIP_RST;
      bin_count_r   <= BIN_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BOX_SIZE:    box_size_r    <= cfg_data[30:0];
        REG_AXIS_MODE:   axis_mode_r   <= cfg_data[1:0];
        REG_FAST_THRESH: fast_thresh_r <= cfg_data;
        REG_BIN_RECIP:   bin_recip_r   <= cfg_data;
        REG_BIN_COUNT:   bin_count_r   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // Combinational helpers
  always_comb begin
    mul_a = (state_r == ST_BMUL) ? dist_r : ax_r[sq_cnt_r];
    mul_b = (state_r == ST_BMUL) ? bin_recip_r : ax_r[sq_cnt_r];

    sq_sum  = {1'b0, sq_r} + {1'b0, prod_r};
    ovf_now = ovf_r | sq_sum[64];

    root_trial = res_r + bit_r;
    root_ge    = (rem_r >= root_trial);
    rem_nxt    = root_ge ? (rem_r - root_trial) : rem_r;
    res_nxt    = root_ge ? ((res_r >> 1) + bit_r) : (res_r >> 1);

    bin_idx    = prod_r[63:32];
    bin_limit  = (32'(bin_count_r) < 32'(BINS)) ? 32'(bin_count_r) : 32'(BINS);
    binned_now = !ovf_r && (bin_idx < bin_limit);

    sum_add = {1'b0, sums_r[sp_r]} + {1'b0, sq_r};

    mem_we    = (state_r == ST_CLEAR) || ((state_r == ST_UPD) && hit_r);
    mem_waddr = (state_r == ST_CLEAR) ? clr_cnt_r : addr_r;
    mem_wdata = (state_r == ST_CLEAR) ? 32'd0 :
                ((mem_q_r == 32'hFFFF_FFFF) ? mem_q_r : mem_q_r + 32'd1);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == ADDR_W'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) state_nxt = (in_data.mode == MODE_READ) ? ST_ADDR : ST_DIFF;
      end
      ST_DIFF: state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_MIN;
      ST_MIN:  state_nxt = ST_SQR;
      ST_SQR:  state_nxt = ST_SQA;
      ST_SQA: begin
        if (axis_mode_r == AXIS_RADIAL) begin
          if (sq_cnt_r < 2'd2)  state_nxt = ST_SQR;
          else if (ovf_now)     state_nxt = ST_BCHK;
          else                  state_nxt = ST_ROOT;
        end else begin
          state_nxt = ST_BMUL;
        end
      end
      ST_ROOT: begin
        if (bit_r[0]) state_nxt = ST_BMUL;
      end
      ST_BMUL: state_nxt = ST_BCHK;
      ST_BCHK: state_nxt = ST_ADDR;
      ST_ADDR: state_nxt = ST_MRD;
      ST_MRD:  state_nxt = (mode_r == MODE_READ) ? ST_OUT : ST_UPD;
      ST_UPD:  state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers: state, clear counter, output valid, species sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_SPECIES; i++) begin
        sums_r[i] <= 64'd0;
      end
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      // add the square to the species sum, saturating
      if ((state_r == ST_UPD) && summed_r) begin
        sums_r[sp_r] <= sum_add[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum_add[63:0];
      end
    end
  end

  // Histogram memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) hist_mem[mem_waddr] <= mem_wdata;
    if (state_r == ST_MRD) mem_q_r <= hist_mem[addr_r];
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        // capture the item
        if (in_acc) begin
          mode_r    <= in_data.mode;
          old_r[0]  <= in_data.old_x;
          old_r[1]  <= in_data.old_y;
          old_r[2]  <= in_data.old_z;
          new_r[0]  <= in_data.new_x;
          new_r[1]  <= in_data.new_y;
          new_r[2]  <= in_data.new_z;
          if (in_data.mode == MODE_READ) begin
            sp_r   <= in_data.read_species;
            bin_r  <= BIN_W'(in_data.read_bin);
            idx8_r <= in_data.read_bin;
            hit_r  <= (in_data.read_species < 3'(NUM_SPECIES)) &&
                      (32'(in_data.read_bin) < 32'(BINS));
          end else begin
            sp_r <= classify_charge(in_data.ion_charge);
          end
        end
      end
      ST_DIFF: begin
        // exact per-axis displacement
        for (int i = 0; i < 3; i++) begin
          d_r[i] <= $signed({new_r[i][31], new_r[i]}) - $signed({old_r[i][31], old_r[i]});
        end
      end
      ST_MAG: begin
        // three image candidates per axis
        for (int i = 0; i < 3; i++) begin
          logic signed [33:0] dm, dp, dd;
          dd = $signed({d_r[i][32], d_r[i]});
          dm = dd - $signed({3'b000, box_size_r});
          dp = dd + $signed({3'b000, box_size_r});
          m0_r[i] <= dd[33] ? 33'(-dd) : 33'(dd);
          m1_r[i] <= dm[33] ? 33'(-dm) : 33'(dm);
          m2_r[i] <= dp[33] ? 33'(-dp) : 33'(dp);
        end
      end
      ST_MIN: begin
        // keep the nearest image, set up the square pass
        for (int i = 0; i < 3; i++) begin
          logic [32:0] a;
          a = m0_r[i];
          if (m1_r[i] < a) a = m1_r[i];
          if (m2_r[i] < a) a = m2_r[i];
          ax_r[i] <= a[31:0];
        end
        sq_cnt_r <= (axis_mode_r == AXIS_RADIAL) ? 2'd0 : (axis_mode_r - 2'd1);
        sq_r     <= 64'd0;
        ovf_r    <= 1'b0;
      end
      ST_SQR: prod_r <= 64'(mul_a) * 64'(mul_b);
      ST_SQA: begin
        // accumulate squares, advance axis, start the root, or skip it on overflow or single axis
        ovf_r <= ovf_now;
        if (axis_mode_r == AXIS_RADIAL) begin
          if (sq_cnt_r < 2'd2) begin
            sq_r     <= sq_sum[63:0];
            sq_cnt_r <= sq_cnt_r + 2'd1;
          end else if (ovf_now) begin
            sq_r   <= 64'hFFFF_FFFF_FFFF_FFFF;
            dist_r <= 32'hFFFF_FFFF;
          end else begin
            sq_r  <= sq_sum[63:0];
            rem_r <= sq_sum[63:0];
            res_r <= 64'd0;
            bit_r <= 64'h4000_0000_0000_0000;
          end
        end else begin
          sq_r   <= sq_sum[63:0];
          dist_r <= ax_r[sq_cnt_r];
        end
      end
      ST_ROOT: begin
        // one result bit per step
        rem_r <= rem_nxt;
        res_r <= res_nxt;
        bit_r <= bit_r >> 2;
        if (bit_r[0]) dist_r <= res_nxt[31:0];
      end
      ST_BMUL: prod_r <= 64'(mul_a) * 64'(mul_b);
      ST_BCHK: begin
        hit_r    <= binned_now;
        summed_r <= ovf_r || (dist_r > fast_thresh_r);
        bin_r    <= BIN_W'(bin_idx);
        idx8_r   <= binned_now ? bin_idx[7:0] : 8'd0;
      end
      ST_ADDR: begin
        addr_r <= hit_r ? ADDR_W'(32'(sp_r) * 32'(BINS) + 32'(bin_r)) : '0;
      end
      ST_OUT: begin
        // load the output register
        if (out_load) begin
          out_r.species   <= sp_r;
          out_r.bin_index <= idx8_r;
          if (mode_r == MODE_READ) begin
            out_r.distance   <= 32'd0;
            out_r.binned     <= 1'b0;
            out_r.summed     <= 1'b0;
            out_r.hist_count <= hit_r ? mem_q_r : 32'd0;
            out_r.square_sum <= (sp_r < 3'(NUM_SPECIES)) ? sums_r[sp_r] : 64'd0;
          end else begin
            out_r.distance   <= dist_r;
            out_r.binned     <= hit_r;
            out_r.summed     <= summed_r;
            out_r.hist_count <= 32'd0;
            out_r.square_sum <= 64'd0;
          end
        end
      end
      default: ;
    endcase
  end

  // Checks
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken again right after an item was accepted");

  a_update_species: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD) |-> (sp_r < 3'(NUM_SPECIES)))
    else $error("accumulate update with species out of range");

  a_ovf_not_binned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ADDR && mode_r == MODE_ACCUM && ovf_r) |-> !hit_r)
    else $error("overflowed distance was binned");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_UPD && hit_r) |-> (32'(addr_r) < 32'(DEPTH)))
    else $error("histogram write beyond the memory");

endmodule

`default_nettype wire
